[src/frw_pkg.sv]
// ----------------------------------------------------------------------------
// frw_pkg
// Shared types, constants and fixed-point helpers for the falloff ramp block.
// ----------------------------------------------------------------------------
package frw_pkg;

    localparam int POINTS_MAX = 16;
    localparam int IDX_W      = $clog2(POINTS_MAX);
    localparam int CNT_W      = $clog2(POINTS_MAX + 1);

    localparam int Q_W        = 17;
    localparam int RAD_W      = 24;
    localparam int NUM_W      = 40;
    localparam int DEN_W      = 24;
    localparam int OP_W       = 21;
    localparam int PROD_W     = 2 * OP_W;
    localparam int ACC_W      = 44;

    localparam logic [Q_W-1:0] ONE_Q16 = 17'd65536;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] MODE_STEP   = 2'd0;
    localparam logic [1:0] MODE_LINEAR = 2'd1;
    localparam logic [1:0] MODE_SMOOTH = 2'd2;
    localparam logic [1:0] MODE_SPLINE = 2'd3;

    typedef struct packed {
        logic [Q_W-1:0] pos;
        logic [Q_W-1:0] val;
        logic [1:0]     mode;
    } t_key;

    // round to nearest after scaling by 2^-16, ties toward plus infinity
    function automatic logic signed [ACC_W-1:0] rq16(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] s;
        s = x + 44'sd32768;
        return s >>> 16;
    endfunction

    function automatic logic [Q_W-1:0] clamp_unit(input logic signed [ACC_W-1:0] x);
        logic [Q_W-1:0] r;
        if (x < 0) begin
            r = '0;
        end else if (x > 44'sd65536) begin
            r = ONE_Q16;
        end else begin
            r = x[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

[src/frw_table.sv]
// ----------------------------------------------------------------------------
// frw_table
// Key point store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module frw_table (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [frw_pkg::IDX_W-1:0]  i_waddr,
    input  frw_pkg::t_key              i_wdata,
    input  logic [frw_pkg::IDX_W-1:0]  i_raddr,
    output frw_pkg::t_key              o_rdata
);

    frw_pkg::t_key r_mem [frw_pkg::POINTS_MAX];
    frw_pkg::t_key r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/frw_div.sv]
// ----------------------------------------------------------------------------
// frw_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module frw_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_go,
    input  logic [frw_pkg::NUM_W-1:0]  i_num,
    input  logic [frw_pkg::DEN_W-1:0]  i_den,
    output logic                       o_done,
    output logic [frw_pkg::NUM_W-1:0]  o_quo,
    output logic                       o_rem_nz
);

    localparam int CW = $clog2(frw_pkg::NUM_W + 1);

    logic                       r_run;
    logic                       r_done;
    logic [CW-1:0]              r_cnt;
    logic [frw_pkg::NUM_W-1:0]  r_q;
    logic [frw_pkg::DEN_W-1:0]  r_rem;
    logic [frw_pkg::DEN_W-1:0]  r_den;
    logic [frw_pkg::DEN_W:0]    trial;
    logic [frw_pkg::DEN_W:0]    shifted;

    assign shifted = {r_rem, r_q[frw_pkg::NUM_W-1]};
    assign trial   = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_run <= 1'b1;
                r_cnt <= CW'(frw_pkg::NUM_W);
                r_q   <= i_num;
                r_rem <= '0;
                r_den <= i_den;
            end else if (r_run) begin
                if (trial[frw_pkg::DEN_W]) begin
                    r_rem <= shifted[frw_pkg::DEN_W-1:0];
                    r_q   <= {r_q[frw_pkg::NUM_W-2:0], 1'b0};
                end else begin
                    r_rem <= trial[frw_pkg::DEN_W-1:0];
                    r_q   <= {r_q[frw_pkg::NUM_W-2:0], 1'b1};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_quo    = r_q;
    assign o_rem_nz = |r_rem;

endmodule

[src/falloff_ramp_weight.sv]
// ----------------------------------------------------------------------------
// falloff_ramp_weight
// Soft selection weight from a piecewise ramp of sorted key points.
// ----------------------------------------------------------------------------
// Usage:
//   Commands are issued on start and transfer when start is high and busy is
//   low. Clear finishes at once. Add inserts the key in position order by
//   moving later keys up one slot, reading and then writing each moved key.
//   A query returns one weight on o_weight for one cycle with o_weight_valid;
//   the receiver cannot stall. Selected or out-of-radius queries answer in
//   the next cycle; others divide for the ramp position and, if keys exist,
//   scan them one at a time; a position between two keys then divides for
//   the segment parameter, and a linear or smooth segment adds multiply
//   steps, a spline up to two tangent divisions and Hermite multiplies. The
//   user writes the radius register over the APB port only while idle; the
//   block does not enforce this. Reset empties the ramp and sets the radius
//   to 256; key storage is not cleared.
// ----------------------------------------------------------------------------
module falloff_ramp_weight (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [16:0] i_key_position,
    input  logic [16:0] i_key_value,
    input  logic [1:0]  i_key_mode,
    input  logic [23:0] i_distance,
    input  logic        i_is_selected,
    output logic [16:0] o_weight,
    output logic        o_weight_valid,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SW = 5;
    localparam logic [SW-1:0] S_IDLE   = 5'd0;
    localparam logic [SW-1:0] S_ADD_RD = 5'd1;
    localparam logic [SW-1:0] S_ADD_WR = 5'd2;
    localparam logic [SW-1:0] S_PDIV   = 5'd3;
    localparam logic [SW-1:0] S_SC0    = 5'd4;
    localparam logic [SW-1:0] S_SC_RD  = 5'd5;
    localparam logic [SW-1:0] S_SC_CHK = 5'd6;
    localparam logic [SW-1:0] S_N_CHK  = 5'd7;
    localparam logic [SW-1:0] S_T_GO   = 5'd8;
    localparam logic [SW-1:0] S_T_WAIT = 5'd9;
    localparam logic [SW-1:0] S_LIN    = 5'd10;
    localparam logic [SW-1:0] S_SM1    = 5'd11;
    localparam logic [SW-1:0] S_SM2    = 5'd12;
    localparam logic [SW-1:0] S_SM3    = 5'd13;
    localparam logic [SW-1:0] S_H_SPAN = 5'd14;
    localparam logic [SW-1:0] S_H_MD   = 5'd15;
    localparam logic [SW-1:0] S_H_MW   = 5'd16;
    localparam logic [SW-1:0] S_HT     = 5'd17;
    localparam logic [SW-1:0] S_HT2    = 5'd18;
    localparam logic [SW-1:0] S_HT3    = 5'd19;
    localparam logic [SW-1:0] S_HH     = 5'd20;
    localparam logic [SW-1:0] S_HA1    = 5'd21;
    localparam logic [SW-1:0] S_HA2    = 5'd22;
    localparam logic [SW-1:0] S_HA3    = 5'd23;
    localparam logic [SW-1:0] S_HA4    = 5'd24;

    localparam int QW = frw_pkg::Q_W;
    localparam int OW = frw_pkg::OP_W;
    localparam int AW = frw_pkg::ACC_W;

    logic [SW-1:0]               r_state, n_state;
    logic [frw_pkg::CNT_W-1:0]   r_count, n_count;
    logic [frw_pkg::CNT_W-1:0]   r_idx, n_idx;
    logic [frw_pkg::RAD_W-1:0]   r_radius;
    frw_pkg::t_key               r_new, n_new;
    logic [QW-1:0]               r_p, n_p;
    frw_pkg::t_key               r_l, n_l;
    frw_pkg::t_key               r_pk, n_pk;
    frw_pkg::t_key               r_r, n_r;
    frw_pkg::t_key               r_nk, n_nk;
    logic [QW-1:0]               r_t, n_t;
    logic [QW-1:0]               r_t2, n_t2;
    logic [QW-1:0]               r_t3, n_t3;
    logic signed [OW-1:0]        r_m0, n_m0;
    logic signed [OW-1:0]        r_m1, n_m1;
    logic signed [OW-1:0]        r_ma, n_ma;
    logic signed [OW-1:0]        r_mb, n_mb;
    logic signed [AW-1:0]        r_acc, n_acc;
    logic                        r_neg, n_neg;
    logic                        r_side, n_side;
    logic [QW-1:0]               r_w, n_w;
    logic                        r_wv, n_wv;

    logic                        accept;
    logic                        cfg_wr;
    logic                        tab_we;
    logic [frw_pkg::IDX_W-1:0]   tab_waddr;
    frw_pkg::t_key               tab_wdata;
    logic [frw_pkg::IDX_W-1:0]   tab_raddr;
    frw_pkg::t_key               tab_rdata;
    logic                        div_go;
    logic [frw_pkg::NUM_W-1:0]   div_num;
    logic [frw_pkg::DEN_W-1:0]   div_den;
    logic                        div_done;
    logic [frw_pkg::NUM_W-1:0]   div_quo;
    logic                        div_rem_nz;

    logic signed [frw_pkg::PROD_W-1:0] mul;
    logic signed [AW-1:0]        mul_x;
    logic signed [AW-1:0]        lval_x;
    logic signed [OW-1:0]        d_s;
    logic [QW-1:0]               w_u;
    logic signed [OW-1:0]        span_s;
    logic signed [OW-1:0]        diff_s;
    logic signed [AW-1:0]        n_num;
    logic [AW-1:0]               n_mag;
    logic signed [OW-1:0]        q_s;
    logic signed [OW-1:0]        m_res;
    logic signed [OW-1:0]        t_s, t2_s, t3_s;
    logic signed [OW-1:0]        h00, h10, h01, h11;
    logic signed [AW-1:0]        rq_mul;
    logic [QW-1:0]               pos_c, val_c;

    frw_table u_table (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (tab_wdata),
        .i_raddr (tab_raddr),
        .o_rdata (tab_rdata)
    );

    frw_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (div_go),
        .i_num    (div_num),
        .i_den    (div_den),
        .o_done   (div_done),
        .o_quo    (div_quo),
        .o_rem_nz (div_rem_nz)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
    assign pready = 1'b1;
    assign prdata = {8'd0, r_radius};

    assign o_weight       = r_w;
    assign o_weight_valid = r_wv;

    assign mul    = r_ma * r_mb;
    assign mul_x  = AW'(mul);
    assign rq_mul = frw_pkg::rq16(mul_x);
    assign lval_x = $signed({{(AW-QW){1'b0}}, r_l.val});
    assign d_s    = $signed({4'd0, r_r.val}) - $signed({4'd0, r_l.val});
    assign w_u    = r_r.pos - r_l.pos;
    assign span_s = r_side ? ($signed({4'd0, r_nk.pos}) - $signed({4'd0, r_l.pos}))
                           : ($signed({4'd0, r_r.pos}) - $signed({4'd0, r_pk.pos}));
    assign diff_s = r_side ? ($signed({4'd0, r_nk.val}) - $signed({4'd0, r_l.val}))
                           : ($signed({4'd0, r_r.val}) - $signed({4'd0, r_pk.val}));
    assign n_num  = (mul_x <<< 1) + AW'(span_s);
    assign n_mag  = n_num[AW-1] ? AW'(-n_num) : AW'(n_num);
    assign q_s    = $signed(div_quo[OW-1:0]) + $signed({{(OW-1){1'b0}}, div_rem_nz});
    assign m_res  = r_neg ? -q_s : $signed(div_quo[OW-1:0]);
    assign t_s    = $signed({4'd0, r_t});
    assign t2_s   = $signed({4'd0, r_t2});
    assign t3_s   = $signed({4'd0, r_t3});
    assign h00    = (t3_s <<< 1) - 21'sd3 * t2_s + 21'sd65536;
    assign h10    = t3_s - (t2_s <<< 1) + t_s;
    assign h01    = 21'sd3 * t2_s - (t3_s <<< 1);
    assign h11    = t3_s - t2_s;
    assign pos_c  = (i_key_position > frw_pkg::ONE_Q16) ? frw_pkg::ONE_Q16 : i_key_position;
    assign val_c  = (i_key_value > frw_pkg::ONE_Q16) ? frw_pkg::ONE_Q16 : i_key_value;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_new   = r_new;
        n_p     = r_p;
        n_l     = r_l;
        n_pk    = r_pk;
        n_r     = r_r;
        n_nk    = r_nk;
        n_t     = r_t;
        n_t2    = r_t2;
        n_t3    = r_t3;
        n_m0    = r_m0;
        n_m1    = r_m1;
        n_ma    = r_ma;
        n_mb    = r_mb;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_side  = r_side;
        n_w     = r_w;
        n_wv    = 1'b0;
        tab_we    = 1'b0;
        tab_waddr = r_idx[frw_pkg::IDX_W-1:0];
        tab_wdata = r_new;
        tab_raddr = '0;
        div_go    = 1'b0;
        div_num   = '0;
        div_den   = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_command)
                        frw_pkg::CMD_CLEAR: begin
                            n_count = '0;
                        end
                        frw_pkg::CMD_ADD: begin
                            n_new = '{pos: pos_c, val: val_c, mode: i_key_mode};
                            if (r_count < frw_pkg::CNT_W'(frw_pkg::POINTS_MAX)) begin
                                n_idx   = r_count;
                                n_state = S_ADD_RD;
                            end
                        end
                        frw_pkg::CMD_QUERY: begin
                            if (i_is_selected) begin
                                n_w  = frw_pkg::ONE_Q16;
                                n_wv = 1'b1;
                            end else if (r_radius == '0 || i_distance > r_radius) begin
                                n_w  = '0;
                                n_wv = 1'b1;
                            end else begin
                                div_go  = 1'b1;
                                div_num = {i_distance, 16'd0};
                                div_den = r_radius;
                                n_state = S_PDIV;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ADD_RD: begin
                if (r_idx == '0) begin
                    tab_we  = 1'b1;
                    n_count = r_count + 1'b1;
                    n_state = S_IDLE;
                end else begin
                    tab_raddr = frw_pkg::IDX_W'(r_idx - 1'b1);
                    n_state   = S_ADD_WR;
                end
            end
            S_ADD_WR: begin
                tab_we = 1'b1;
                if (tab_rdata.pos > r_new.pos) begin
                    tab_wdata = tab_rdata;
                    n_idx     = r_idx - 1'b1;
                    n_state   = S_ADD_RD;
                end else begin
                    n_count = r_count + 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_PDIV: begin
                if (div_done) begin
                    n_p = div_quo[QW-1:0];
                    if (r_count == '0) begin
                        n_w     = (div_quo[QW-1:0] == '0) ? frw_pkg::ONE_Q16 : '0;
                        n_wv    = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_SC0;
                    end
                end
            end
            S_SC0: begin
                if (r_count == frw_pkg::CNT_W'(1) || r_p < tab_rdata.pos) begin
                    n_w     = tab_rdata.val;
                    n_wv    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_l     = tab_rdata;
                    n_pk    = tab_rdata;
                    n_idx   = frw_pkg::CNT_W'(1);
                    n_state = S_SC_RD;
                end
            end
            S_SC_RD: begin
                if (r_idx >= r_count) begin
                    n_w     = r_l.val;
                    n_wv    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    tab_raddr = r_idx[frw_pkg::IDX_W-1:0];
                    n_state   = S_SC_CHK;
                end
            end
            S_SC_CHK: begin
                if (tab_rdata.pos <= r_p) begin
                    n_pk    = r_l;
                    n_l     = tab_rdata;
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SC_RD;
                end else begin
                    n_r = tab_rdata;
                    if (r_idx + 1'b1 < r_count) begin
                        tab_raddr = frw_pkg::IDX_W'(r_idx + 1'b1);
                        n_state   = S_N_CHK;
                    end else begin
                        n_nk    = tab_rdata;
                        n_state = S_T_GO;
                    end
                end
            end
            S_N_CHK: begin
                n_nk    = tab_rdata;
                n_state = S_T_GO;
            end
            S_T_GO: begin
                div_go  = 1'b1;
                div_num = {7'd0, r_p - r_l.pos, 16'd0};
                div_den = {7'd0, w_u};
                n_state = S_T_WAIT;
            end
            S_T_WAIT: begin
                if (div_done) begin
                    n_t = div_quo[QW-1:0];
                    case (r_l.mode)
                        frw_pkg::MODE_STEP: begin
                            n_w     = frw_pkg::clamp_unit(lval_x);
                            n_wv    = 1'b1;
                            n_state = S_IDLE;
                        end
                        frw_pkg::MODE_LINEAR: begin
                            n_ma    = $signed({4'd0, div_quo[QW-1:0]});
                            n_mb    = d_s;
                            n_state = S_LIN;
                        end
                        frw_pkg::MODE_SMOOTH: begin
                            n_ma    = $signed({4'd0, div_quo[QW-1:0]});
                            n_mb    = $signed({4'd0, div_quo[QW-1:0]});
                            n_state = S_SM1;
                        end
                        default: begin
                            n_side  = 1'b0;
                            n_state = S_H_SPAN;
                        end
                    endcase
                end
            end
            S_LIN: begin
                n_w     = frw_pkg::clamp_unit(lval_x + frw_pkg::rq16(mul_x));
                n_wv    = 1'b1;
                n_state = S_IDLE;
            end
            S_SM1: begin
                n_ma    = rq_mul[OW-1:0];
                n_mb    = 21'sd196608 - $signed({3'd0, r_t, 1'b0});
                n_state = S_SM2;
            end
            S_SM2: begin
                n_ma    = rq_mul[OW-1:0];
                n_mb    = d_s;
                n_state = S_SM3;
            end
            S_SM3: begin
                n_w     = frw_pkg::clamp_unit(lval_x + rq_mul);
                n_wv    = 1'b1;
                n_state = S_IDLE;
            end
            S_H_SPAN: begin
                if (span_s > 0) begin
                    n_ma    = $signed({4'd0, w_u});
                    n_mb    = diff_s;
                    n_state = S_H_MD;
                end else begin
                    if (r_side) begin
                        n_m1    = d_s;
                        n_state = S_HT;
                    end else begin
                        n_m0    = d_s;
                        n_side  = 1'b1;
                    end
                end
            end
            S_H_MD: begin
                n_neg   = n_num[AW-1];
                div_go  = 1'b1;
                div_num = n_mag[frw_pkg::NUM_W-1:0];
                div_den = frw_pkg::DEN_W'({span_s[OW-2:0], 1'b0});
                n_state = S_H_MW;
            end
            S_H_MW: begin
                if (div_done) begin
                    if (r_side) begin
                        n_m1    = m_res;
                        n_state = S_HT;
                    end else begin
                        n_m0    = m_res;
                        n_side  = 1'b1;
                        n_state = S_H_SPAN;
                    end
                end
            end
            S_HT: begin
                n_ma    = t_s;
                n_mb    = t_s;
                n_state = S_HT2;
            end
            S_HT2: begin
                n_t2    = rq_mul[QW-1:0];
                n_ma    = rq_mul[OW-1:0];
                n_mb    = t_s;
                n_state = S_HT3;
            end
            S_HT3: begin
                n_t3    = rq_mul[QW-1:0];
                n_state = S_HH;
            end
            S_HH: begin
                n_ma    = h00;
                n_mb    = $signed({4'd0, r_l.val});
                n_state = S_HA1;
            end
            S_HA1: begin
                n_acc   = mul_x;
                n_ma    = h10;
                n_mb    = r_m0;
                n_state = S_HA2;
            end
            S_HA2: begin
                n_acc   = r_acc + mul_x;
                n_ma    = h01;
                n_mb    = $signed({4'd0, r_r.val});
                n_state = S_HA3;
            end
            S_HA3: begin
                n_acc   = r_acc + mul_x;
                n_ma    = h11;
                n_mb    = r_m1;
                n_state = S_HA4;
            end
            S_HA4: begin
                n_w     = frw_pkg::clamp_unit(frw_pkg::rq16(r_acc + mul_x));
                n_wv    = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_radius <= 24'd256;
            r_wv     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_wv    <= n_wv;
            if (cfg_wr) begin
                r_radius <= pwdata[frw_pkg::RAD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_new  <= n_new;
        r_p    <= n_p;
        r_l    <= n_l;
        r_pk   <= n_pk;
        r_r    <= n_r;
        r_nk   <= n_nk;
        r_t    <= n_t;
        r_t2   <= n_t2;
        r_t3   <= n_t3;
        r_m0   <= n_m0;
        r_m1   <= n_m1;
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_acc  <= n_acc;
        r_neg  <= n_neg;
        r_side <= n_side;
        r_w    <= n_w;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= frw_pkg::CNT_W'(frw_pkg::POINTS_MAX))
        else $error("key count above table depth");

    a_weight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_weight_valid |-> (o_weight <= frw_pkg::ONE_Q16))
        else $error("weight above one");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_weight_valid))
        else $error("not idle after reset");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD_RD && r_idx == '0) |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not bump key count");

endmodule

[tb/tb_falloff_ramp_weight.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_falloff_ramp_weight
// Self-checking bench: directed and random ramp edits and weight queries,
// radius changes over APB, weights compared against an internal ramp model.
// ----------------------------------------------------------------------------

class weight_scoreboard;
    logic [16:0] key_pos[frw_pkg::POINTS_MAX];
    logic [16:0] key_val[frw_pkg::POINTS_MAX];
    logic [1:0]  key_md[frw_pkg::POINTS_MAX];
    int          n_keys;
    logic [23:0] radius;
    logic [16:0] pending_weights[$];
    int          errors;

    function new();
        n_keys = 0;
        radius = 24'd256;
        errors = 0;
    endfunction

    function longint near_div(longint num, longint den);
        longint n, d, q;
        n = 2 * num + den;
        d = 2 * den;
        q = n / d;
        if (n % d != 0 && n < 0) q--;
        return q;
    endfunction

    function longint unit_clamp(longint v);
        if (v < 0) return 0;
        if (v > 65536) return 65536;
        return v;
    endfunction

    function longint ramp_eval(longint p);
        int li, pi, ni;
        longint lv, rv, d, w, t, t2, t3, m0, m1, lspan, rspan, sum;
        li = 0;
        if (n_keys == 0) return (p == 0) ? 65536 : 0;
        if (n_keys == 1 || p < key_pos[0]) return key_val[0];
        while (li + 1 < n_keys && key_pos[li+1] <= p) li++;
        if (li + 1 >= n_keys) return key_val[li];
        w = longint'(key_pos[li+1]) - longint'(key_pos[li]);
        if (w <= 0) return key_val[li+1];
        lv = key_val[li];
        rv = key_val[li+1];
        d = rv - lv;
        t = ((p - longint'(key_pos[li])) * 65536) / w;
        case (key_md[li])
            frw_pkg::MODE_STEP: return unit_clamp(lv);
            frw_pkg::MODE_LINEAR: return unit_clamp(lv + near_div(t * d, 65536));
            frw_pkg::MODE_SMOOTH: begin
                t2 = near_div(t * t, 65536);
                t = near_div(t2 * (3 * 65536 - 2 * t), 65536);
                return unit_clamp(lv + near_div(t * d, 65536));
            end
            default: begin
                pi = (li > 0) ? li - 1 : 0;
                ni = (li + 2 < n_keys) ? li + 2 : n_keys - 1;
                lspan = longint'(key_pos[li+1]) - longint'(key_pos[pi]);
                rspan = longint'(key_pos[ni]) - longint'(key_pos[li]);
                m0 = (lspan > 0) ? near_div(w * (rv - longint'(key_val[pi])), lspan) : d;
                m1 = (rspan > 0) ? near_div(w * (longint'(key_val[ni]) - lv), rspan) : d;
                t2 = near_div(t * t, 65536);
                t3 = near_div(t2 * t, 65536);
                sum = (2*t3 - 3*t2 + 65536) * lv + (t3 - 2*t2 + t) * m0
                    + (-2*t3 + 3*t2) * rv + (t3 - t2) * m1;
                return unit_clamp(near_div(sum, 65536));
            end
        endcase
    endfunction

    function void note_command(logic [1:0] cmd, logic [16:0] pos, logic [16:0] val,
                               logic [1:0] md, logic [23:0] vtx_dist, logic sel);
        int at;
        longint p;
        if (cmd == frw_pkg::CMD_CLEAR) begin
            n_keys = 0;
        end else if (cmd == frw_pkg::CMD_ADD) begin
            if (pos > 65536) pos = 65536;
            if (val > 65536) val = 65536;
            if (n_keys < frw_pkg::POINTS_MAX) begin
                at = n_keys;
                while (at > 0 && key_pos[at-1] > pos) at--;
                for (int i = n_keys; i > at; i--) begin
                    key_pos[i] = key_pos[i-1];
                    key_val[i] = key_val[i-1];
                    key_md[i]  = key_md[i-1];
                end
                key_pos[at] = pos;
                key_val[at] = val;
                key_md[at]  = md;
                n_keys++;
            end
        end else if (cmd == frw_pkg::CMD_QUERY) begin
            if (sel) begin
                pending_weights.push_back(17'd65536);
            end else if (radius == 0 || vtx_dist > radius) begin
                pending_weights.push_back(17'd0);
            end else begin
                p = (longint'(vtx_dist) << 16) / radius;
                pending_weights.push_back(17'(ramp_eval(p)));
            end
        end
    endfunction

    function bit check_weight(logic [16:0] got);
        logic [16:0] want;
        if (pending_weights.size() == 0) return 0;
        want = pending_weights.pop_front();
        return got === want;
    endfunction
endclass

module tb_falloff_ramp_weight;
    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_command;
    logic [16:0] i_key_position;
    logic [16:0] i_key_value;
    logic [1:0]  i_key_mode;
    logic [23:0] i_distance;
    logic        i_is_selected;
    logic [16:0] o_weight;
    logic        o_weight_valid;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    weight_scoreboard sb;
    int               mismatches;

    falloff_ramp_weight i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report(string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_weight_valid) begin
            if (sb.pending_weights.size() == 0) begin
                report($sformatf("unexpected weight %0d", o_weight));
            end else if (!sb.check_weight(o_weight)) begin
                report($sformatf("weight mismatch, got %0d", o_weight));
            end
        end
    end

    task automatic write_radius(logic [23:0] r);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; paddr = 2'd0; pwdata = {8'd0, r};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        sb.radius = r;
    endtask

    // drive one command; start stays high, caller lowers it on gaps
    task automatic send(logic [1:0] cmd, logic [16:0] pos, logic [16:0] val,
                        logic [1:0] md, logic [23:0] vtx_dist, logic sel);
        i_command = cmd; i_key_position = pos; i_key_value = val;
        i_key_mode = md; i_distance = vtx_dist; i_is_selected = sel;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_command(cmd, pos, val, md, vtx_dist, sel);
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(int n);
        start = 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain();
        start = 1'b0;
        while (sb.pending_weights.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic random_item(int qbias);
        int r;
        logic [16:0] pos;
        logic [16:0] val;
        logic [23:0] vtx_dist;
        r = $urandom_range(99);
        pos = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
        val = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
        if ($urandom_range(3) == 0) vtx_dist = 24'($urandom);
        else vtx_dist = 24'($urandom_range(sb.radius + sb.radius / 8 + 1));
        if (r < 3) send(frw_pkg::CMD_CLEAR, pos, val, 2'($urandom), vtx_dist, 1'b0);
        else if (r < 5) send(2'd3, pos, val, 2'($urandom), vtx_dist, 1'($urandom));
        else if (r < 5 + qbias) send(frw_pkg::CMD_ADD, pos, val, 2'($urandom), vtx_dist, 1'b0);
        else send(frw_pkg::CMD_QUERY, pos, val, 2'($urandom), vtx_dist,
                  $urandom_range(15) == 0);
    endtask

    initial begin
        logic [23:0] radii[5];
        sb = new();
        mismatches = 0;
        i_rst_n = 1'b0; start = 1'b0;
        i_command = frw_pkg::CMD_CLEAR; i_key_position = '0; i_key_value = '0;
        i_key_mode = frw_pkg::MODE_STEP; i_distance = '0; i_is_selected = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // empty ramp
        send(frw_pkg::CMD_QUERY, 0, 0, frw_pkg::MODE_STEP, 24'd0, 1'b0);
        send(frw_pkg::CMD_QUERY, 0, 0, frw_pkg::MODE_STEP, 24'd1, 1'b0);
        send(frw_pkg::CMD_QUERY, 0, 0, frw_pkg::MODE_STEP, 24'hFFFFFF, 1'b1);
        send(frw_pkg::CMD_QUERY, 0, 0, frw_pkg::MODE_STEP, 24'd257, 1'b0);
        // single out-of-range key, then one key per mode, a duplicate position and an end key
        send(frw_pkg::CMD_ADD, 17'h1FFFF, 17'h1FFFF, frw_pkg::MODE_SPLINE, 24'hFFFFFF, 1'b1);
        send(frw_pkg::CMD_QUERY, 0, 0, frw_pkg::MODE_STEP, 24'd100, 1'b0);
        send(frw_pkg::CMD_CLEAR, 0, 0, frw_pkg::MODE_STEP, 0, 0);
        send(frw_pkg::CMD_ADD, 17'd8192, 17'd65536, frw_pkg::MODE_STEP, 0, 0);
        send(frw_pkg::CMD_ADD, 17'd20000, 17'd50000, frw_pkg::MODE_LINEAR, 0, 0);
        send(frw_pkg::CMD_ADD, 17'd30000, 17'd10000, frw_pkg::MODE_SMOOTH, 0, 0);
        send(frw_pkg::CMD_ADD, 17'd40000, 17'd60000, frw_pkg::MODE_SPLINE, 0, 0);
        send(frw_pkg::CMD_ADD, 17'd40000, 17'd0, frw_pkg::MODE_SPLINE, 0, 0);
        send(frw_pkg::CMD_ADD, 17'd65536, 17'd30000, frw_pkg::MODE_LINEAR, 0, 0);
        send(2'd3, 17'h1FFFF, 17'h1FFFF, 2'd3, 24'hFFFFFF, 1'b1);
        for (int d = 0; d <= 256; d += 32)
            send(frw_pkg::CMD_QUERY, 0, 0, frw_pkg::MODE_STEP, 24'(d), 1'b0);
        send(frw_pkg::CMD_QUERY, 0, 0, frw_pkg::MODE_STEP, 24'd256, 1'b0);
        drain();

        radii[0] = 24'd0; radii[1] = 24'hFFFFFF; radii[2] = 24'd1;
        radii[3] = 24'd1000; radii[4] = 24'd256;
        for (int ph = 0; ph < 5; ph++) begin
            write_radius(radii[ph]);
            // fill past the key limit in phase 2
            if (ph == 2) for (int k = 0; k < frw_pkg::POINTS_MAX + 2; k++)
                send(frw_pkg::CMD_ADD, 17'($urandom_range(65536)),
                     17'($urandom_range(65536)), 2'($urandom), 0, 0);
            for (int n = 0; n < 120;) begin
                int burst;
                burst = $urandom_range(12, 1);
                for (int b = 0; b < burst && n < 120; b++, n++)
                    random_item((ph % 2) ? 25 : 12);
                if ($urandom_range(2) != 0) idle_cycles($urandom_range(150));
                if (n == 60 && ph == 3) drain();
            end
            drain();
        end

        if (mismatches == 0 && sb.pending_weights.size() == 0) begin
            $display("tb_falloff_ramp_weight passed");
        end else begin
            $display("tb_falloff_ramp_weight failed");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("tb_falloff_ramp_weight failed");
        $finish;
    end
endmodule
